### src/sstm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstm_pkg
// Shared types and constants of the start/stop tag matcher.
// ----------------------------------------------------------------------------
package sstm_pkg;

  localparam int unsigned KeyW     = 8;
  localparam int unsigned TagSlots = 1 << KeyW;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;

  typedef logic [KeyW-1:0] key_t;

  // register index, taken from paddr[2]
  localparam logic REG_START_BASELINE = 1'b0;
  localparam logic REG_STOP_BASELINE  = 1'b1;

endpackage

### src/start_stop_tag_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_stop_tag_matcher
// Pairs start-leg and stop-leg measurements that share a normalized tag.
//
//   channel  | handshake           | beat contents
//   ---------+---------------------+-------------------------------------------
//   in       | in_valid_i/ready_o  | is_start_leg_i, seq_num_i, payload_i
//   out      | out_valid_o/ready_i | match_key_o, start_payload_o, stop_payload_o
//   config   | APB psel/penable    | start_baseline (0x0), stop_baseline (0x4)
//
// One beat per cycle is accepted while in_ready_o is high. The completing
// beat goes through the pending-data memory read into the decision stage,
// then the match decision and table update load the output register.
// Reset clears both pending valid vectors at once; no clearing pass.
// A stalled output register holds the decision stage, and input ready drops.
// ----------------------------------------------------------------------------
module start_stop_tag_matcher #(
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           is_start_leg_i,
  input  sstm_pkg::key_t                 seq_num_i,
  input  logic [PAYLOAD_BITS-1:0]        payload_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sstm_pkg::key_t                 match_key_o,
  output logic [PAYLOAD_BITS-1:0]        start_payload_o,
  output logic [PAYLOAD_BITS-1:0]        stop_payload_o,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sstm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [sstm_pkg::CfgDataW-1:0]  pwdata,
  output logic [sstm_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import sstm_pkg::*;

  key_t                    start_base_q, stop_base_q;

  logic [TagSlots-1:0]     start_vld_q, stop_vld_q;
  logic [PAYLOAD_BITS-1:0] start_mem [TagSlots];
  logic [PAYLOAD_BITS-1:0] stop_mem  [TagSlots];
  logic [PAYLOAD_BITS-1:0] start_rd_q, stop_rd_q;

  logic                    s1_valid_q;
  logic                    s1_start_q;
  key_t                    s1_key_q;
  logic [PAYLOAD_BITS-1:0] s1_payload_q;

  logic                    out_valid_q;
  key_t                    match_key_q;
  logic [PAYLOAD_BITS-1:0] start_payload_q, stop_payload_q;

  logic                    in_accept;
  logic                    cfg_write;
  key_t                    key_d;
  logic                    out_free;
  logic                    s1_fire;
  logic                    peer_vld;
  logic                    own_vld;
  logic                    s1_match;
  logic                    s1_store;
  logic                    start_we, stop_we;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_base_q <= '0;
      stop_base_q  <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_START_BASELINE: start_base_q <= pwdata[KeyW-1:0];
        REG_STOP_BASELINE:  stop_base_q  <= pwdata[KeyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_START_BASELINE: prdata = {{(CfgDataW-KeyW){1'b0}}, start_base_q};
      REG_STOP_BASELINE:  prdata = {{(CfgDataW-KeyW){1'b0}}, stop_base_q};
      default:            prdata = '0;
    endcase
  end

  // handshake and decision
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_accept  = in_valid_i && in_ready_o;

  assign key_d = seq_num_i - (is_start_leg_i ? start_base_q : stop_base_q);

  assign peer_vld = s1_start_q ? stop_vld_q[s1_key_q]  : start_vld_q[s1_key_q];
  assign own_vld  = s1_start_q ? start_vld_q[s1_key_q] : stop_vld_q[s1_key_q];
  assign s1_match = peer_vld;
  assign s1_store = !peer_vld && !own_vld;
  assign start_we = s1_fire && s1_store && s1_start_q;
  assign stop_we  = s1_fire && s1_store && !s1_start_q;

  // decision stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_start_q   <= is_start_leg_i;
      s1_key_q     <= key_d;
      s1_payload_q <= payload_i;
    end
  end

  // pending valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_vld_q <= '0;
      stop_vld_q  <= '0;
    end else if (s1_fire) begin
      if (s1_match) begin
        if (s1_start_q) begin
          stop_vld_q[s1_key_q] <= 1'b0;
        end else begin
          start_vld_q[s1_key_q] <= 1'b0;
        end
      end else if (s1_store) begin
        if (s1_start_q) begin
          start_vld_q[s1_key_q] <= 1'b1;
        end else begin
          stop_vld_q[s1_key_q] <= 1'b1;
        end
      end
    end
  end

  // pending data memories, with bypass of a same-cycle write
  always_ff @(posedge clk_i) begin
    if (start_we) begin
      start_mem[s1_key_q] <= s1_payload_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stop_we) begin
      stop_mem[s1_key_q] <= s1_payload_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (start_we && (s1_key_q == key_d)) begin
        start_rd_q <= s1_payload_q;
      end else begin
        start_rd_q <= start_mem[key_d];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (stop_we && (s1_key_q == key_d)) begin
        stop_rd_q <= s1_payload_q;
      end else begin
        stop_rd_q <= stop_mem[key_d];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_match) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_match) begin
      match_key_q     <= s1_key_q;
      start_payload_q <= s1_start_q ? s1_payload_q : start_rd_q;
      stop_payload_q  <= s1_start_q ? stop_rd_q : s1_payload_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_key_o     = match_key_q;
  assign start_payload_o = start_payload_q;
  assign stop_payload_o  = stop_payload_q;

  // checks
  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked decision stage");

  a_match_clears_peer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_match && s1_start_q) |=> !stop_vld_q[$past(s1_key_q)])
    else $error("matched stop entry still pending");

  a_store_sets_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_store && !s1_start_q) |=> stop_vld_q[$past(s1_key_q)])
    else $error("stored stop entry not marked pending");

  a_result_from_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && s1_match))
    else $error("result raised without a match");

endmodule

### tb/start_stop_tag_matcher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_stop_tag_matcher_checker
// Watches the measurement, pair and register channels of the tag matcher.
// It keeps its own pending tables and baselines and predicts each pair when a
// measurement beat is taken. Each pair beat is compared field by field with
// the oldest prediction. Mismatches and pairs that are still owed go to the
// testbench top.
// ----------------------------------------------------------------------------
module start_stop_tag_matcher_checker #(
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                is_start_leg_i,
  input  sstm_pkg::key_t                      seq_num_i,
  input  logic [PAYLOAD_BITS-1:0]             payload_i,

  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  sstm_pkg::key_t                      match_key_i,
  input  logic [PAYLOAD_BITS-1:0]             start_payload_i,
  input  logic [PAYLOAD_BITS-1:0]             stop_payload_i,

  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic                                pready_i,
  input  logic [sstm_pkg::CfgAddrW-1:0]       paddr_i,
  input  logic [sstm_pkg::CfgDataW-1:0]       pwdata_i,

  output int                                  pairs_owed_o,
  output int                                  mismatches_o
);
  import sstm_pkg::*;

  typedef logic [PAYLOAD_BITS-1:0] meas_t;

  typedef struct {
    key_t  key;
    meas_t start_pl;
    meas_t stop_pl;
  } pair_t;

  pair_t pairs_due[$];
  pair_t want;
  key_t  start_base;
  key_t  stop_base;
  bit    start_held [TagSlots];
  bit    stop_held  [TagSlots];
  meas_t start_meas [TagSlots];
  meas_t stop_meas  [TagSlots];
  int    mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic take_measurement(input logic start_leg, input key_t seq, input meas_t pl);
    key_t  key;
    pair_t fresh;
    key = seq - (start_leg ? start_base : stop_base);
    fresh.key = key;
    if (start_leg) begin
      if (stop_held[key]) begin
        fresh.start_pl = pl;
        fresh.stop_pl  = stop_meas[key];
        pairs_due.push_back(fresh);
        stop_held[key] = 1'b0;
      end else if (!start_held[key]) begin
        start_held[key] = 1'b1;
        start_meas[key] = pl;
      end
    end else begin
      if (start_held[key]) begin
        fresh.start_pl = start_meas[key];
        fresh.stop_pl  = pl;
        pairs_due.push_back(fresh);
        start_held[key] = 1'b0;
      end else if (!stop_held[key]) begin
        stop_held[key] = 1'b1;
        stop_meas[key] = pl;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_due.delete();
      start_base = '0;
      stop_base  = '0;
      foreach (start_held[i]) begin
        start_held[i] = 1'b0;
        stop_held[i]  = 1'b0;
        start_meas[i] = '0;
        stop_meas[i]  = '0;
      end
      pairs_owed_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pairs_due.size() == 0) begin
          report_mismatch($sformatf("pair beat with key %h and none due", match_key_i));
        end else begin
          want = pairs_due.pop_front();
          if (match_key_i !== want.key)
            report_mismatch($sformatf("match_key got %h, expected %h", match_key_i, want.key));
          if (start_payload_i !== want.start_pl)
            report_mismatch($sformatf("start_payload got %h, expected %h (key %h)",
                                      start_payload_i, want.start_pl, want.key));
          if (stop_payload_i !== want.stop_pl)
            report_mismatch($sformatf("stop_payload got %h, expected %h (key %h)",
                                      stop_payload_i, want.stop_pl, want.key));
        end
      end
      if (in_valid_i && in_ready_i) begin
        take_measurement(is_start_leg_i, seq_num_i, payload_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_START_BASELINE) begin
          start_base = pwdata_i[KeyW-1:0];
        end else begin
          stop_base = pwdata_i[KeyW-1:0];
        end
      end
      pairs_owed_o <= pairs_due.size();
    end
  end

endmodule

### tb/start_stop_tag_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_stop_tag_matcher_tb
// Drives start and stop measurements and baseline writes into the tag matcher.
// A directed part covers the key extremes, duplicate keys, back-to-back hits,
// key wrap and a baseline change while entries are pending. Random rounds
// follow. Keys mostly come from a small drifting window so that pairs form
// often, with some noise items mixed in. Sender and receiver stall at varying
// rates. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module start_stop_tag_matcher_tb;
  import sstm_pkg::*;

  localparam int unsigned PayloadW    = 64;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RoundBeats  = 175;
  localparam int unsigned Rounds      = 6;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 is_start_leg_i = 1'b0;
  key_t                 seq_num_i = '0;
  logic [PayloadW-1:0]  payload_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  key_t                 match_key_o;
  logic [PayloadW-1:0]  start_payload_o;
  logic [PayloadW-1:0]  stop_payload_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [CfgAddrW-1:0]  paddr = '0;
  logic [CfgDataW-1:0]  pwdata = '0;
  logic [CfgDataW-1:0]  prdata;
  logic                 pready;

  int send_idle_pct = 12;
  int recv_idle_pct = 65;
  int pairs_owed;
  int mismatches;

  logic [7:0] start_sched [Rounds] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
  logic [7:0] stop_sched  [Rounds] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};

  always #6 clk_i = ~clk_i;

  start_stop_tag_matcher #(
    .PAYLOAD_BITS(PayloadW)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .is_start_leg_i (is_start_leg_i),
    .seq_num_i      (seq_num_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .match_key_o    (match_key_o),
    .start_payload_o(start_payload_o),
    .stop_payload_o (stop_payload_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  start_stop_tag_matcher_checker #(
    .PAYLOAD_BITS(PayloadW)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .is_start_leg_i (is_start_leg_i),
    .seq_num_i      (seq_num_i),
    .payload_i      (payload_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .match_key_i    (match_key_o),
    .start_payload_i(start_payload_o),
    .stop_payload_i (stop_payload_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pairs_owed_o   (pairs_owed),
    .mismatches_o   (mismatches)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_meas(input logic start_leg, input key_t seq,
                           input logic [PayloadW-1:0] pl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    is_start_leg_i <= start_leg;
    seq_num_i      <= seq;
    payload_i      <= pl;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold the sender until every owed pair is out and the pipeline is empty
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pairs_owed != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    logic [CfgDataW-1:0] noise;
    noise = $urandom;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {noise[CfgDataW-1:8], value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int         window;
    logic       leg;
    key_t       seq;
    logic [7:0] sb;
    logic [7:0] pb;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_meas(1'b1, 8'h00, 64'h0);
    send_meas(1'b0, 8'h00, '1);
    send_meas(1'b1, 8'hFF, '1);
    send_meas(1'b1, 8'hFF, 64'h1234);
    send_meas(1'b0, 8'hFF, 64'h0);
    send_meas(1'b0, 8'h55, 64'hAAAA_AAAA_AAAA_AAAA);
    send_meas(1'b0, 8'h55, 64'h5555_5555_5555_5555);
    send_meas(1'b1, 8'h55, 64'h5555_5555_5555_5555);
    send_meas(1'b0, 8'hAA, 64'h1);
    send_meas(1'b1, 8'hAA, 64'h2);
    send_meas(1'b1, 8'h10, 64'h3);
    send_meas(1'b1, 8'h10, 64'h4);
    send_meas(1'b0, 8'h10, 64'h5);
    send_meas(1'b0, 8'h10, 64'h6);
    send_meas(1'b1, 8'h20, 64'h7);
    drain();
    write_reg(REG_START_BASELINE, 8'h80);
    write_reg(REG_STOP_BASELINE, 8'h7F);
    send_meas(1'b0, 8'h9F, 64'h8);
    send_meas(1'b1, 8'h05, 64'h9);
    send_meas(1'b0, 8'h04, 64'hA);
    send_meas(1'b1, 8'h90, 64'hB);

    window = 0;
    for (int r = 0; r < Rounds; r++) begin
      drain();
      if (r < 2) begin
        send_idle_pct = 12;
        recv_idle_pct = 65;
      end else if (r < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (r == 3 || r == 4) begin
        sb = 8'($urandom);
        pb = 8'($urandom);
      end else begin
        sb = start_sched[r];
        pb = stop_sched[r];
      end
      write_reg(REG_START_BASELINE, sb);
      write_reg(REG_STOP_BASELINE, pb);
      for (int i = 0; i < RoundBeats; i++) begin
        if (i == RoundBeats / 2) drain();
        if (i % 16 == 0) window = window + 8;
        leg = 1'($urandom_range(1));
        if ($urandom_range(9) == 0) begin
          seq = key_t'($urandom);
        end else begin
          seq = key_t'(window + $urandom_range(15)) + (leg ? sb : pb);
        end
        send_meas(leg, seq, {$urandom, $urandom});
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
